// File: hdl/rrt_pkg.sv
// Package for the ranked result table: sizes, key and link types, state codes.
// Used by rrt_cell, rrt_read_tree and ranked_result_table.
package rrt_pkg;

  localparam int CAPACITY = 64;

  localparam int ID_W    = 32;
  localparam int SCORE_W = 32;
  localparam int RANK_W  = 6;
  localparam int ENTRY_W = 7;
  localparam int STAT_W  = 2;
  localparam int KEY_W   = SCORE_W + ID_W;

  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 72;

  // Occupancy count, wide enough to hold CAPACITY itself.
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > RANK_W) ? CNT_W : RANK_W;

  // Read tree: groups of eight cells, then one of the groups.
  localparam int GRP_W    = 3;
  localparam int GRP_SIZE = 1 << GRP_W;
  localparam int HI_W     = RANK_W - GRP_W;
  localparam int SLOTS    = 1 << HI_W;

  typedef logic [KEY_W-1:0] key_t;
  typedef key_t [CAPACITY-1:0] key_row_t;

  // What each cell hands to the next cell down the chain.
  typedef struct packed {
    logic ahead;  // this cell stays ahead of the new pair
    key_t key;
  } link_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_RANGE = 2'd2
  } status_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_READ = 1'b1
  } state_t;

  localparam logic MODE_ADD  = 1'b0;
  localparam logic MODE_READ = 1'b1;

  // The score's sign bit is inverted so that unsigned key order is rank order.
  function automatic key_t make_key(input logic [SCORE_W-1:0] score,
                                    input logic [ID_W-1:0] doc_id);
    make_key = {~score[SCORE_W-1], score[SCORE_W-2:0], doc_id};
  endfunction

endpackage

// File: hdl/rrt_cell.sv
// One compare-and-shift cell of the ranked table.
// Depends on rrt_pkg for the key and link types.
module rrt_cell
  import rrt_pkg::*;
(
  input  logic  clk,
  input  logic  ins_en,
  input  key_t  new_key,
  input  logic  occupied,
  input  link_t prev_link,
  output link_t link
);

  key_t key;

  assign link.key   = key;
  assign link.ahead = occupied && (key >= new_key);

  // A cell behind the insertion point takes the new pair if its upper
  // neighbor stays ahead, otherwise the neighbor's pair moves down.
  always_ff @(posedge clk) begin
    if (ins_en && !link.ahead) begin
      key <= prev_link.ahead ? new_key : prev_link.key;
    end
  end

endmodule

// File: hdl/rrt_read_tree.sv
// Two-level selection of the cell at a requested rank; the first level is registered.
// Depends on rrt_pkg for sizes and the key row type.
module rrt_read_tree
  import rrt_pkg::*;
(
  input  logic              clk,
  input  logic              capture,
  input  logic [RANK_W-1:0] rank,
  input  key_row_t          keys,
  output key_t              key_sel
);

  key_t                     cand [SLOTS][GRP_SIZE];
  key_t                     grp_key [SLOTS];
  logic [HI_W-1:0]          rank_hi;

  for (genvar g = 0; g < SLOTS; g++) begin : g_slot
    for (genvar j = 0; j < GRP_SIZE; j++) begin : g_entry
      if (g * GRP_SIZE + j < CAPACITY) begin : g_used
        assign cand[g][j] = keys[g * GRP_SIZE + j];
      end else begin : g_pad
        assign cand[g][j] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (capture) begin
      for (int g = 0; g < SLOTS; g++) begin
        grp_key[g] <= cand[g][rank[GRP_W-1:0]];
      end
      rank_hi <= rank[RANK_W-1:GRP_W];
    end
  end

  assign key_sel = grp_key[rank_hi];

endmodule

// File: hdl/ranked_result_table.sv
// Top level of the ranked result table: control, output register and cell chain.
// Depends on rrt_pkg, rrt_cell and rrt_read_tree.
//
// Keeps up to CAPACITY (relevancy, document id) pairs in descending rank order,
// relevancy first and higher id first on equal relevancy. Items come in on the
// s_ stream; s_tuser selects add (0) or read (1). Every item gives exactly one
// result transfer on the m_ stream, with the status in m_tuser.
// On an add, every cell compares its pair with the new one in parallel and
// the cells behind the insertion point shift down by one, so the result is
// valid the cycle after the transfer. A full table drops the pair and reports
// full. A read goes through a two-level selection (eight cells, then one of
// eight groups), registered after the first level, then the output register;
// the block takes no item while in the read state, before the result is loaded.
// A result waits in the output register while the receiver stalls; a new item
// is taken only in the idle state, when that register is empty or being drained.
// Synchronous reset empties the table; the cell contents themselves are not
// cleared, since only ranks below the count are ever read.
module ranked_result_table
  import rrt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // doc_id[31:0], score[63:32], rank[69:64], zeros
  input  logic                  s_tuser,   // mode
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // out_doc_id[31:0], out_score[63:32],
                                           // entry_count[70:64], zero
  output logic [STAT_W-1:0]     m_tuser    // status
);

  state_t state, state_next;

  logic [CNT_W-1:0]   count;
  logic               accept;
  logic               add_acc;
  logic               read_acc;
  logic               read_done;
  logic               full;
  logic               ins_en;
  logic               in_range;
  logic               in_range_next;

  logic [ID_W-1:0]    in_doc_id;
  logic [SCORE_W-1:0] in_score;
  logic [RANK_W-1:0]  in_rank;
  key_t               new_key;

  link_t              links [CAPACITY];
  key_row_t           keys;
  key_t               key_sel;

  logic [ID_W-1:0]    out_doc_id;
  logic [SCORE_W-1:0] out_score;
  status_t            status;
  logic [ENTRY_W-1:0] entry_count;

  assign in_doc_id = s_tdata[ID_W-1:0];
  assign in_score  = s_tdata[ID_W+SCORE_W-1:ID_W];
  assign in_rank   = s_tdata[ID_W+SCORE_W+RANK_W-1:ID_W+SCORE_W];
  assign new_key   = make_key(in_score, in_doc_id);

  assign accept   = s_tvalid && s_tready;
  assign add_acc  = accept && (s_tuser == MODE_ADD);
  assign read_acc = accept && (s_tuser == MODE_READ);
  assign full     = (count == CNT_W'(CAPACITY));
  assign ins_en   = add_acc && !full;

  assign in_range_next = (CMP_W'(in_rank) < CMP_W'(count)) &&
                         (CMP_W'(in_rank) < CMP_W'(CAPACITY));

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (read_acc) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State-dependent outputs.
  always_comb begin
    s_tready  = 1'b0;
    read_done = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = !m_tvalid || m_tready;
      end
      ST_READ: begin
        read_done = 1'b1;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (ins_en) begin
        count <= count + 1'b1;
      end
    end
  end

  // The cell chain. Cell 0 has nothing ahead of it.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    link_t prev;
    logic  occ;

    if (i == 0) begin : g_head
      assign prev = '{ahead: 1'b1, key: new_key};
    end else begin : g_body
      assign prev = links[i-1];
    end

    assign occ     = (CMP_W'(i) < CMP_W'(count));
    assign keys[i] = links[i].key;

    rrt_cell u_cell (
      .clk       (clk),
      .ins_en    (ins_en),
      .new_key   (new_key),
      .occupied  (occ),
      .prev_link (prev),
      .link      (links[i])
    );
  end

  rrt_read_tree u_read_tree (
    .clk     (clk),
    .capture (read_acc),
    .rank    (in_rank),
    .keys    (keys),
    .key_sel (key_sel)
  );

  always_ff @(posedge clk) begin
    if (read_acc) begin
      in_range <= in_range_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (add_acc || read_done) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (add_acc) begin
      out_doc_id  <= '0;
      out_score   <= '0;
      status      <= full ? STAT_FULL : STAT_OK;
      entry_count <= full ? ENTRY_W'(count) : ENTRY_W'(count + 1'b1);
    end else if (read_done) begin
      entry_count <= ENTRY_W'(count);
      if (in_range) begin
        out_doc_id <= key_sel[ID_W-1:0];
        out_score  <= {~key_sel[KEY_W-1], key_sel[KEY_W-2:ID_W]};
        status     <= STAT_OK;
      end else begin
        out_doc_id <= '0;
        out_score  <= '0;
        status     <= STAT_RANGE;
      end
    end
  end

  assign m_tdata = {(OUT_DATA_W - ID_W - SCORE_W - ENTRY_W)'(0),
                    entry_count, out_score, out_doc_id};
  assign m_tuser = status;

endmodule

// File: tb/ranked_result_table_tb.sv
// Self-checking testbench for ranked_result_table: random and directed add and read
// transfers, with results checked against a ranked copy of the table kept here.
// Depends on rrt_pkg and the ranked_result_table RTL.
`timescale 1ns / 100ps

module ranked_result_table_tb;
  import rrt_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  typedef struct {
    logic [ID_W-1:0]    doc_id;
    logic [SCORE_W-1:0] score;
    status_t            status;
    logic [ENTRY_W-1:0] count;
  } table_response_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  s_tuser = MODE_ADD;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [STAT_W-1:0]     m_tuser;

  int idle_pct  = 0;
  int stall_pct = 0;
  int holdoff_target = 0;
  int holdoff_done   = 0;
  int cycle_count    = 0;
  int fail_count     = 0;
  int adds_offered   = 0;

  // Local copy of the table: keys with the score sign inverted, so unsigned order
  // of the keys is rank order.
  logic [KEY_W-1:0] ranked_keys [CAPACITY];
  int               ranked_count = 0;
  table_response_t  pending_responses [$];

  ranked_result_table dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d responses outstanding", $time,
               pending_responses.size());
      $display("FAIL");
      $finish;
    end
  end

  function automatic table_response_t predict_table_response(
      input logic mode, input logic [ID_W-1:0] doc_id,
      input logic [SCORE_W-1:0] score, input logic [RANK_W-1:0] rank);
    table_response_t  resp;
    logic [KEY_W-1:0] key;
    int               pos;
    resp.doc_id = '0;
    resp.score  = '0;
    resp.status = STAT_OK;
    if (mode == MODE_ADD) begin
      if (ranked_count >= CAPACITY) begin
        resp.status = STAT_FULL;
      end else begin
        key = {~score[SCORE_W-1], score[SCORE_W-2:0], doc_id};
        pos = 0;
        while (pos < ranked_count && ranked_keys[pos] >= key) pos++;
        for (int k = ranked_count; k > pos; k--) ranked_keys[k] = ranked_keys[k-1];
        ranked_keys[pos] = key;
        ranked_count++;
      end
    end else if (int'(rank) >= ranked_count) begin
      resp.status = STAT_RANGE;
    end else begin
      key = ranked_keys[rank];
      resp.doc_id = key[ID_W-1:0];
      resp.score  = {~key[KEY_W-1], key[KEY_W-2:ID_W]};
    end
    resp.count = ENTRY_W'(ranked_count);
    return resp;
  endfunction

  // Receiver: random stalls, plus long hold-offs requested by the tests.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (holdoff_done != holdoff_target) begin
      m_tready <= 1'b0;
      holdoff_done <= holdoff_done + 1;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Checker: compares each result transfer with the oldest expectation, then
  // records the expectation for any item accepted at the same edge.
  always @(posedge clk) begin
    table_response_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (pending_responses.size() == 0) begin
          $display("%0t: unexpected result, actual id %h score %h status %0d count %0d",
                   $time, m_tdata[31:0], m_tdata[63:32], m_tuser, m_tdata[70:64]);
          fail_count++;
        end else begin
          want = pending_responses.pop_front();
          if (m_tdata[31:0] !== want.doc_id) begin
            $display("%0t: doc id mismatch, expected %h actual %h",
                     $time, want.doc_id, m_tdata[31:0]);
            fail_count++;
          end
          if (m_tdata[63:32] !== want.score) begin
            $display("%0t: score mismatch, expected %h actual %h",
                     $time, want.score, m_tdata[63:32]);
            fail_count++;
          end
          if (m_tuser !== want.status) begin
            $display("%0t: status mismatch, expected %s actual %0d",
                     $time, want.status.name(), m_tuser);
            fail_count++;
          end
          if (m_tdata[70:64] !== want.count) begin
            $display("%0t: entry count mismatch, expected %0d actual %0d",
                     $time, want.count, m_tdata[70:64]);
            fail_count++;
          end
        end
      end
      if (s_tvalid && s_tready)
        pending_responses.insert(pending_responses.size(), predict_table_response(
            s_tuser, s_tdata[31:0], s_tdata[63:32], s_tdata[69:64]));
    end
  end

  // Offers one item and returns at the edge where the transfer takes place.
  task automatic send_item(input logic mode, input logic [ID_W-1:0] doc_id,
                           input logic [SCORE_W-1:0] score,
                           input logic [RANK_W-1:0] rank);
    while ($urandom_range(0, 99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= {2'b00, rank, score, doc_id};
    if (mode == MODE_ADD) adds_offered++;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic send_random_item(input int add_pct);
    logic [ID_W-1:0]    doc_id;
    logic [SCORE_W-1:0] score;
    logic [RANK_W-1:0]  rank;
    int                 held;
    // Scores and ids come from small pools often enough to give ties.
    case ($urandom_range(0, 11))
      0: score = 32'h7FFF_FFFF;
      1: score = 32'h8000_0000;
      2: score = 32'h0000_0000;
      3: score = 32'h0001_0000;
      default: score = $urandom;
    endcase
    doc_id = ($urandom_range(0, 2) != 0) ? $urandom : $urandom_range(0, 3);
    held = (adds_offered < CAPACITY) ? adds_offered : CAPACITY;
    if (held != 0 && $urandom_range(0, 1) != 0) rank = RANK_W'($urandom_range(0, held - 1));
    else rank = RANK_W'($urandom_range(0, 63));
    if ($urandom_range(0, 99) < add_pct) send_item(MODE_ADD, doc_id, score, rank);
    else send_item(MODE_READ, doc_id, score, rank);
  endtask

  // Empty table reads, score and id extremes, ties on score and identical pairs.
  task automatic test_directed();
    send_item(MODE_READ, $urandom, $urandom, 6'd0);
    send_item(MODE_READ, $urandom, $urandom, 6'd63);
    send_item(MODE_ADD, 32'hFFFF_FFFF, 32'h7FFF_FFFF, RANK_W'($urandom));
    send_item(MODE_ADD, 32'h0000_0000, 32'h8000_0000, RANK_W'($urandom));
    send_item(MODE_ADD, 32'd5, 32'h0000_0000, RANK_W'($urandom));
    send_item(MODE_ADD, 32'd9, 32'h0000_0000, RANK_W'($urandom));
    send_item(MODE_ADD, 32'd5, 32'h0000_0000, RANK_W'($urandom));
    send_item(MODE_ADD, 32'd7, 32'hFFFF_FFFF, RANK_W'($urandom));
    send_item(MODE_ADD, 32'hFFFF_FFFF, 32'h0001_0000, RANK_W'($urandom));
    send_item(MODE_ADD, 32'hFFFF_FFFF, 32'h8000_0000, RANK_W'($urandom));
    for (int r = 0; r < 8; r++) send_item(MODE_READ, $urandom, $urandom, RANK_W'(r));
    send_item(MODE_READ, $urandom, $urandom, 6'd8);
    send_item(MODE_READ, $urandom, $urandom, 6'd63);
  endtask

  // Random inserts at every depth until the table is full, then some dropped adds.
  task automatic test_fill_random();
    while (adds_offered < CAPACITY) send_random_item(65);
    repeat (20) send_random_item(50);
  endtask

  task automatic test_reads_random(input int count);
    repeat (count) send_random_item(20);
  endtask

  // The receiver holds off long enough for the block to stall its input.
  task automatic test_output_holdoff();
    holdoff_target <= holdoff_target + 300;
    repeat (40) send_random_item(30);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    idle_pct  = 30;
    stall_pct = 72;
    test_directed();
    test_fill_random();

    idle_pct  = 72;
    stall_pct = 30;
    test_reads_random(200);

    idle_pct  = 0;
    stall_pct = 0;
    test_output_holdoff();
    test_reads_random(130);
    s_tvalid <= 1'b0;

    while (pending_responses.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
